>>> rtl/core/crceng_pkg.sv
// ----------------------------------------------------------------------------
// crceng_pkg
// Shared types, constants and helpers of the configurable CRC byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crceng_pkg;

    // Widest remainder the datapath carries, and the narrowest one allowed.
    localparam int unsigned CRC_MAX_BITS   = 64;
    localparam int unsigned CRC_MIN_BITS   = 8;
    localparam int unsigned CRC_SHIFT_BITS = $clog2(CRC_MAX_BITS);
    localparam int unsigned CRC_WBITS      = 7;
    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned CFG_IDX_BITS   = 3;

    // Reset values of the configuration registers.
    localparam logic [CRC_WBITS-1:0]    RST_CRC_BITS    = 7'd32;
    localparam logic [CRC_MAX_BITS-1:0] RST_GENERATOR   = 64'h0000_0000_04C1_1DB7;
    localparam logic [CRC_MAX_BITS-1:0] RST_START_VALUE = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CRC_MAX_BITS-1:0] RST_OUTPUT_XOR  = 64'h0000_0000_FFFF_FFFF;
    localparam logic                    RST_REFLECT_IN  = 1'b1;
    localparam logic                    RST_REFLECT_OUT = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CRC_BITS    = 3'd0,
        CFG_GENERATOR   = 3'd1,
        CFG_START_VALUE = 3'd2,
        CFG_OUTPUT_XOR  = 3'd3,
        CFG_REFLECT_IN  = 3'd4,
        CFG_REFLECT_OUT = 3'd5
    } cfg_reg_t;

    // Values derived from the registers, in the forms the update logic uses.
    typedef struct packed {
        logic [CRC_SHIFT_BITS-1:0] align_shift;  // CRC_MAX_BITS minus the width
        logic [CRC_MAX_BITS-1:0]   width_mask;   // ones in the low width bits
        logic [CRC_MAX_BITS-1:0]   poly_left;    // generator, top-aligned
        logic [CRC_MAX_BITS-1:0]   poly_refl;    // generator reversed within width
        logic [CRC_MAX_BITS-1:0]   start_masked;
        logic [CRC_MAX_BITS-1:0]   xor_masked;
        logic                      reflect_in;
        logic                      reflect_out;
    } crc_cfg_t;

    // Full-word bit reversal; a right shift afterwards reverses within a width.
    function automatic logic [CRC_MAX_BITS-1:0] bitrev(input logic [CRC_MAX_BITS-1:0] v);
        logic [CRC_MAX_BITS-1:0] r;
        for (int i = 0; i < CRC_MAX_BITS; i++) begin
            r[CRC_MAX_BITS-1-i] = v[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/configurable_crc_byte_engine.sv
// ----------------------------------------------------------------------------
// configurable_crc_byte_engine
// CRC engine, 8 to 64 bit remainder, one message byte per clock unless stalled.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata[7:0] = data_byte, tlast = last_byte
//  m_axis    out        tdata[63:0] = crc_value (low crc_bits bits, rest zero)
//  cfg       in         cfg_index = register number, cfg_data = value
//
//  The engine takes one byte per clock while input ready is high. A byte is
//  held in the input register, then the eight-step XOR-shift update folds
//  it into the remainder register; a byte marked last loads the finished CRC
//  into the output register, from which the result is offered. Reset clears
//  the pipeline and loads the register defaults (CRC-32, both reflections
//  on). When the output register is full and not taken, a last byte waits in
//  the input register and input ready drops; other bytes keep flowing. The
//  configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module configurable_crc_byte_engine (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    // Byte input. tdata: [7:0] data_byte.
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [crceng_pkg::BYTE_BITS-1:0]       s_tdata,
    input  wire logic                                   s_tlast,

    // Result output. tdata: [63:0] crc_value.
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [crceng_pkg::CRC_MAX_BITS-1:0]    m_tdata,

    // Configuration writes.
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [crceng_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [crceng_pkg::CRC_MAX_BITS-1:0]    cfg_data
);

    crceng_pkg::crc_cfg_t cfg;

    // Input register stage.
    logic                                in_valid_reg;
    logic [crceng_pkg::BYTE_BITS-1:0]    in_byte_reg;
    logic                                in_last_reg;

    // Running remainder, kept right-aligned; reflected when reflect_in is set.
    logic [crceng_pkg::CRC_MAX_BITS-1:0] rem_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] rem_next;
    logic                                busy_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] out_crc_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] crc_next;

    logic                                advance;
    logic                                s_fire;

    assign cfg_ready = 1'b1;

    crceng_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    crceng_update u_update (
        .cfg       (cfg),
        .rem_in    (rem_reg),
        .busy      (busy_reg),
        .data_byte (in_byte_reg),
        .rem_out   (rem_next),
        .crc_value (crc_next)
    );

    // The held byte is processed unless it finishes a message and the output
    // register still holds a result that is not taken in this cycle.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                busy_reg <= !in_last_reg;

            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            rem_reg <= rem_next;
        if (advance && in_last_reg)
            out_crc_reg <= crc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

endmodule

`default_nettype wire

>>> rtl/core/crceng_cfg_regs.sv
// ----------------------------------------------------------------------------
// crceng_cfg_regs
// Configuration registers and the values derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module crceng_cfg_regs (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      wr_en,
    input  wire logic [crceng_pkg::CFG_IDX_BITS-1:0]       wr_index,
    input  wire logic [crceng_pkg::CRC_MAX_BITS-1:0]       wr_data,
    output crceng_pkg::crc_cfg_t                           cfg
);

    logic [crceng_pkg::CRC_WBITS-1:0]    crc_bits_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] generator_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] start_value_reg;
    logic [crceng_pkg::CRC_MAX_BITS-1:0] output_xor_reg;
    logic                                reflect_in_reg;
    logic                                reflect_out_reg;

    logic [crceng_pkg::CRC_WBITS-1:0]      eff_width;
    logic [crceng_pkg::CRC_WBITS-1:0]      shift_full;
    logic [crceng_pkg::CRC_SHIFT_BITS-1:0] shift;
    logic [crceng_pkg::CRC_MAX_BITS-1:0]   mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_bits_reg    <= crceng_pkg::RST_CRC_BITS;
            generator_reg   <= crceng_pkg::RST_GENERATOR;
            start_value_reg <= crceng_pkg::RST_START_VALUE;
            output_xor_reg  <= crceng_pkg::RST_OUTPUT_XOR;
            reflect_in_reg  <= crceng_pkg::RST_REFLECT_IN;
            reflect_out_reg <= crceng_pkg::RST_REFLECT_OUT;
        end
        else if (wr_en)
        begin
            case (crceng_pkg::cfg_reg_t'(wr_index))
                crceng_pkg::CFG_CRC_BITS:    crc_bits_reg    <= wr_data[crceng_pkg::CRC_WBITS-1:0];
                crceng_pkg::CFG_GENERATOR:   generator_reg   <= wr_data;
                crceng_pkg::CFG_START_VALUE: start_value_reg <= wr_data;
                crceng_pkg::CFG_OUTPUT_XOR:  output_xor_reg  <= wr_data;
                crceng_pkg::CFG_REFLECT_IN:  reflect_in_reg  <= wr_data[0];
                crceng_pkg::CFG_REFLECT_OUT: reflect_out_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Out-of-range widths are clamped into the supported span.
    always_comb
    begin
        if (crc_bits_reg < crceng_pkg::CRC_WBITS'(crceng_pkg::CRC_MIN_BITS))
            eff_width = crceng_pkg::CRC_WBITS'(crceng_pkg::CRC_MIN_BITS);
        else if (crc_bits_reg > crceng_pkg::CRC_WBITS'(crceng_pkg::CRC_MAX_BITS))
            eff_width = crceng_pkg::CRC_WBITS'(crceng_pkg::CRC_MAX_BITS);
        else
            eff_width = crc_bits_reg;
    end

    assign shift_full = crceng_pkg::CRC_WBITS'(crceng_pkg::CRC_MAX_BITS) - eff_width;
    assign shift      = shift_full[crceng_pkg::CRC_SHIFT_BITS-1:0];
    assign mask       = {crceng_pkg::CRC_MAX_BITS{1'b1}} >> shift;

    assign cfg.align_shift  = shift;
    assign cfg.width_mask   = mask;
    assign cfg.poly_left    = generator_reg << shift;
    assign cfg.poly_refl    = crceng_pkg::bitrev(generator_reg) >> shift;
    assign cfg.start_masked = start_value_reg & mask;
    assign cfg.xor_masked   = output_xor_reg & mask;
    assign cfg.reflect_in   = reflect_in_reg;
    assign cfg.reflect_out  = reflect_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/crceng_update.sv
// ----------------------------------------------------------------------------
// crceng_update
// One-byte remainder update and result formatting, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module crceng_update (
    input  crceng_pkg::crc_cfg_t                         cfg,
    input  wire logic [crceng_pkg::CRC_MAX_BITS-1:0]     rem_in,
    input  wire logic                                    busy,
    input  wire logic [crceng_pkg::BYTE_BITS-1:0]        data_byte,
    output logic      [crceng_pkg::CRC_MAX_BITS-1:0]     rem_out,
    output logic      [crceng_pkg::CRC_MAX_BITS-1:0]     crc_value
);

    localparam int unsigned W = crceng_pkg::CRC_MAX_BITS;
    localparam int unsigned B = crceng_pkg::BYTE_BITS;

    logic [W-1:0] cur;
    logic [W-1:0] refl_rem;
    logic [W-1:0] left_rem;
    logic [W-1:0] pre_xor;
    logic         flip;

    // A new message starts from the start value; otherwise the stored
    // remainder is trimmed to the width in force now.
    assign cur  = busy ? (rem_in & cfg.width_mask) : cfg.start_masked;
    assign flip = cfg.reflect_in ^ cfg.reflect_out;

    // Reflected form works right-aligned and shifts toward bit 0. The normal
    // form works top-aligned in the full word, so the feedback tap is always
    // the top bit whatever the width.
    always_comb
    begin
        refl_rem = cur ^ {{(W-B){1'b0}}, data_byte};
        for (int k = 0; k < B; k++) begin
            if (refl_rem[0])
                refl_rem = (refl_rem >> 1) ^ cfg.poly_refl;
            else
                refl_rem = refl_rem >> 1;
        end

        left_rem = (cur << cfg.align_shift) ^ {data_byte, {(W-B){1'b0}}};
        for (int k = 0; k < B; k++) begin
            if (left_rem[W-1])
                left_rem = (left_rem << 1) ^ cfg.poly_left;
            else
                left_rem = left_rem << 1;
        end
    end

    always_comb
    begin
        if (cfg.reflect_in)
        begin
            rem_out = refl_rem;
            pre_xor = flip ? (crceng_pkg::bitrev(refl_rem) >> cfg.align_shift) : refl_rem;
        end
        else
        begin
            rem_out = left_rem >> cfg.align_shift;
            pre_xor = flip ? crceng_pkg::bitrev(left_rem) : (left_rem >> cfg.align_shift);
        end
    end

    assign crc_value = (pre_xor ^ cfg.xor_masked) & cfg.width_mask;

endmodule

`default_nettype wire

>>> rtl/core/crceng_checker.sv
// ----------------------------------------------------------------------------
// crceng_checker
// Port-level checks of the CRC byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crceng_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   s_tvalid,
    input wire logic                                   s_tready,
    input wire logic                                   m_tvalid,
    input wire logic                                   m_tready,
    input wire logic [crceng_pkg::CRC_MAX_BITS-1:0]    m_tdata,
    input wire logic                                   cfg_ready
);

    // A result beat that is not taken stays unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // With the output register empty, nothing can block the byte input.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("byte input stalled with empty output");

    // Leaving reset, the pipeline is empty and ready for a byte.
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> s_tready && !m_tvalid)
        else $error("pipeline not empty after reset");

    // Configuration writes are never refused.
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid || !s_tvalid |-> cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind configurable_crc_byte_engine crceng_checker u_crceng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the configurable CRC byte engine.
// A short table of directed beats goes first. It covers the CRC-32 check
// string, the extreme widths, clamping of out-of-range widths, ignored high
// register bits, a reflection mismatch and a register change in mid-message.
// Random phases follow, each with a fresh register set and one of four idling
// patterns. Every finished CRC is checked against a local bit-serial model of
// the engine or, where a directed row carries one, a hand-typed value.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crceng_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;     // engine latency plus margin
    localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_BYTES   = 150;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned BURST_BYTES   = 60;
    localparam int unsigned NUM_ROWS      = 40;

    typedef enum logic {ROW_REG, ROW_BYTE} row_kind_t;

    // One directed step: either a register write or a data beat. A data beat
    // may carry a hand-typed CRC; otherwise the model computes it.
    typedef struct packed {
        row_kind_t               kind;
        cfg_reg_t                idx;
        logic [CRC_MAX_BITS-1:0] value;
        logic                    last;
        logic                    known;
        logic [CRC_MAX_BITS-1:0] typed_crc;
    } stim_row_t;

    localparam logic [CRC_MAX_BITS-1:0] ONES = {CRC_MAX_BITS{1'b1}};
    localparam logic [CRC_MAX_BITS-1:0] NONE = '0;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Default CRC-32 on the check string "123456789".
        '{ROW_BYTE, CFG_CRC_BITS,    64'h31, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h32, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h33, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h34, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h35, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h36, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h37, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h38, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h39, 1'b1, 1'b1, 64'hCBF4_3926},
        '{ROW_BYTE, CFG_CRC_BITS,    64'hFF, 1'b1, 1'b0, NONE},
        // Full 64-bit width, no reflection, zero start: a zero byte leaves
        // only the output XOR.
        '{ROW_REG,  CFG_CRC_BITS,    64'd64, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_GENERATOR,   ONES,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_START_VALUE, NONE,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_OUTPUT_XOR,  ONES,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_REFLECT_IN,  NONE,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_REFLECT_OUT, NONE,   1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h00, 1'b1, 1'b1, ONES},
        '{ROW_BYTE, CFG_CRC_BITS,    64'hFF, 1'b1, 1'b0, NONE},
        // Width 0 clamps to 8; the start value's bits above the width are
        // dropped; reflections differ so the result gets mirrored.
        '{ROW_REG,  CFG_CRC_BITS,    64'd0,  1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_GENERATOR,   64'h07, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_START_VALUE, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_OUTPUT_XOR,  NONE,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_REFLECT_IN,  64'd1,  1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h00, 1'b1, 1'b1, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'hA5, 1'b1, 1'b0, NONE},
        // Width 127 clamps to 64. Halfway through the message the width,
        // generator and start value change; the remainder gets masked.
        '{ROW_REG,  CFG_CRC_BITS,    64'd127, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_REFLECT_IN,  NONE,   1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_REFLECT_OUT, 64'd1,  1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h80, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h01, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_CRC_BITS,    64'd16, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_GENERATOR,   64'h1021, 1'b0, 1'b0, NONE},
        '{ROW_REG,  CFG_START_VALUE, 64'h1D0F, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h55, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'hAA, 1'b1, 1'b0, NONE},
        // Widths just outside the legal range on both sides.
        '{ROW_REG,  CFG_CRC_BITS,    64'd65, 1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h3C, 1'b1, 1'b0, NONE},
        '{ROW_REG,  CFG_CRC_BITS,    64'd7,  1'b0, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'hC3, 1'b1, 1'b0, NONE},
        '{ROW_BYTE, CFG_CRC_BITS,    64'h5A, 1'b1, 1'b0, NONE}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [BYTE_BITS-1:0]    s_tdata = '0;     // [7:0] data_byte
    logic                    s_tlast = 1'b0;   // last_byte
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CRC_MAX_BITS-1:0] m_tdata;          // [63:0] crc_value
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_reg_t                cfg_index = CFG_CRC_BITS;
    logic [CRC_MAX_BITS-1:0] cfg_data = '0;

    // Local copy of the register file and the running remainder.
    logic [CRC_WBITS-1:0]    reg_width;
    logic [CRC_MAX_BITS-1:0] reg_generator;
    logic [CRC_MAX_BITS-1:0] reg_start;
    logic [CRC_MAX_BITS-1:0] reg_xor;
    logic                    reg_refl_in;
    logic                    reg_refl_out;
    logic [CRC_MAX_BITS-1:0] running_rem;
    logic                    msg_open;

    logic [CRC_MAX_BITS-1:0] crc_expected [$];
    logic [CRC_MAX_BITS-1:0] crc_want;
    int unsigned             err_count = 0;
    int unsigned             quiet_cycles = 0;
    int unsigned             tx_idle_pct = 0;
    int unsigned             rx_stall_pct = 0;
    int unsigned             rx_hold_left = 0;

    configurable_crc_byte_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (reg_width < CRC_MIN_BITS)
            return CRC_MIN_BITS;
        if (reg_width > CRC_MAX_BITS)
            return CRC_MAX_BITS;
        return reg_width;
    endfunction

    function automatic logic [CRC_MAX_BITS-1:0] low_ones(input int unsigned w);
        return (w >= CRC_MAX_BITS) ? ONES : ((64'd1 << w) - 64'd1);
    endfunction

    // Mirror the low w bits; everything above w comes out zero.
    function automatic logic [CRC_MAX_BITS-1:0] mirror_low(input logic [CRC_MAX_BITS-1:0] v,
                                                          input int unsigned w);
        logic [CRC_MAX_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < w; i++)
            r[w-1-i] = v[i];
        return r;
    endfunction

    // Fold one byte into the running remainder. Returns 1 and the finished
    // CRC when the byte closes a message.
    function automatic logic crc_absorb(input logic [BYTE_BITS-1:0] b, input logic l,
                                        output logic [CRC_MAX_BITS-1:0] crc);
        int unsigned             w;
        logic [CRC_MAX_BITS-1:0] msk;
        logic [CRC_MAX_BITS-1:0] poly;
        logic [CRC_MAX_BITS-1:0] rem;
        w   = active_width();
        msk = low_ones(w);
        crc = '0;
        if (!msg_open)
            running_rem = reg_start & msk;
        rem = running_rem & msk;
        if (reg_refl_in)
        begin
            poly = mirror_low(reg_generator, w);
            rem ^= {56'd0, b};
            for (int k = 0; k < 8; k++)
                rem = rem[0] ? ((rem >> 1) ^ poly) : (rem >> 1);
        end
        else
        begin
            poly = reg_generator & msk;
            rem ^= {56'd0, b} << (w - 8);
            for (int k = 0; k < 8; k++)
                rem = rem[w-1] ? (((rem << 1) ^ poly) & msk) : ((rem << 1) & msk);
        end
        rem &= msk;
        if (!l)
        begin
            running_rem = rem;
            msg_open    = 1'b1;
            return 1'b0;
        end
        if (reg_refl_in != reg_refl_out)
            rem = mirror_low(rem, w);
        crc         = (rem ^ reg_xor) & msk;
        running_rem = reg_start & msk;
        msg_open    = 1'b0;
        return 1'b1;
    endfunction

    // Offer one byte beat, with random idle cycles ahead of it. Called and
    // returns at a falling edge; tvalid stays high for a following beat.
    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic l, input logic known,
                             input logic [CRC_MAX_BITS-1:0] typed_crc);
        logic [CRC_MAX_BITS-1:0] crc;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (crc_absorb(b, l, crc))
            crc_expected.push_back(known ? typed_crc : crc);
        @(negedge clk);
    endtask

    // Stop offering, let every pending CRC come out, then give the pipeline
    // time to fold in any trailing bytes that produce no result.
    task automatic drain_engine();
        s_tvalid <= 1'b0;
        while (crc_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CRC_MAX_BITS-1:0] val);
        drain_engine();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CRC_BITS:    reg_width     = val[CRC_WBITS-1:0];
            CFG_GENERATOR:   reg_generator = val;
            CFG_START_VALUE: reg_start     = val;
            CFG_OUTPUT_XOR:  reg_xor       = val;
            CFG_REFLECT_IN:  reg_refl_in   = val[0];
            CFG_REFLECT_OUT: reg_refl_out  = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Result side: a long hold-off when asked for, otherwise random stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left != 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (crc_expected.size() == 0)
                begin
                    $error("crc_value: unexpected beat, expected none, actual %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    crc_want = crc_expected.pop_front();
                    if (m_tdata !== crc_want)
                    begin
                        $error("crc_value: expected %h, actual %h", crc_want, m_tdata);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned             w;
        logic [CRC_MAX_BITS-1:0] word;

        reg_width     = RST_CRC_BITS;
        reg_generator = RST_GENERATOR;
        reg_start     = RST_START_VALUE;
        reg_xor       = RST_OUTPUT_XOR;
        reg_refl_in   = RST_REFLECT_IN;
        reg_refl_out  = RST_REFLECT_OUT;
        running_rem   = '0;
        msg_open      = 1'b0;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_REG)
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
            else
                send_byte(DIRECTED_ROWS[i].value[BYTE_BITS-1:0], DIRECTED_ROWS[i].last,
                          DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].typed_crc);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // Mostly legal widths, now and then anything the field holds.
            if (p == 0)
                w = CRC_MAX_BITS;
            else if (p == 1)
                w = CRC_MIN_BITS;
            else if ($urandom_range(0, 3) == 0)
                w = $urandom_range(0, 127);
            else
                w = $urandom_range(CRC_MIN_BITS, CRC_MAX_BITS);
            word = {$urandom, $urandom};
            word[CRC_WBITS-1:0] = w[CRC_WBITS-1:0];
            write_reg(CFG_CRC_BITS, word);
            write_reg(CFG_GENERATOR, {$urandom, $urandom});
            write_reg(CFG_START_VALUE, {$urandom, $urandom});
            write_reg(CFG_OUTPUT_XOR, {$urandom, $urandom});
            write_reg(CFG_REFLECT_IN, {$urandom, $urandom});
            write_reg(CFG_REFLECT_OUT, {$urandom, $urandom});

            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 49;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 49;
                end
                default:
                begin
                    tx_idle_pct  = 11;
                    rx_stall_pct = 11;
                end
            endcase

            // Back-pressure: the result side holds off while a burst of
            // one-byte messages keeps coming, so the output register fills
            // and the engine has to stall its input.
            if (p == 4)
                rx_hold_left = HOLD_CYCLES;

            for (int n = 0; n < PHASE_BYTES; n++)
            begin
                if (p == 6 && n == PHASE_BYTES / 2)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                    while (crc_expected.size() != 0)
                        @(negedge clk);
                end
                send_byte(BYTE_BITS'($urandom_range(0, 255)),
                          (p == 4 && n < BURST_BYTES) ? 1'b1 : ($urandom_range(0, 4) == 0),
                          1'b0, NONE);
            end
        end

        drain_engine();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/core/crceng_pkg.sv
rtl/core/crceng_cfg_regs.sv
rtl/core/crceng_update.sv
rtl/core/configurable_crc_byte_engine.sv
rtl/core/crceng_checker.sv
dv/tb.sv
